// ----- rtl/core/rts_pkg.sv -----
// Shared types, constants and codes of the repeated timer scheduler.
`default_nettype none
package rts_pkg;

   localparam int Depth       = 16;
   localparam int SlotW       = 4;
   localparam int CountW      = 5;
   localparam int TimeW       = 63;
   localparam int PeriodW     = 46;
   localparam int HandleW     = 16;
   localparam int MsW         = 32;
   localparam int WaitW       = 16;
   localparam int TpmW        = 14;

   localparam logic [TpmW-1:0]  TicksPerMs   = 14'd10000;
   localparam logic [TimeW-1:0] TicksPerSec  = 63'd10000000;
   localparam logic [TimeW-1:0] TimeMax      = {TimeW{1'b1}};
   localparam logic [MsW-1:0]   MinInterval  = 32'd5;
   localparam logic [WaitW-1:0] WaitReset    = 16'd50;

   // operation codes
   localparam logic [1:0] OpAdd     = 2'd0;
   localparam logic [1:0] OpRemove  = 2'd1;
   localparam logic [1:0] OpProcess = 2'd2;
   localparam logic [1:0] OpClear   = 2'd3;

   // result kinds
   localparam logic [2:0] KindDispatch = 3'd0;
   localparam logic [2:0] KindAdded    = 3'd1;
   localparam logic [2:0] KindTooShort = 3'd2;
   localparam logic [2:0] KindFull     = 3'd3;
   localparam logic [2:0] KindRemoved  = 3'd4;
   localparam logic [2:0] KindWake     = 3'd5;
   localparam logic [2:0] KindCleared  = 3'd6;

   typedef struct packed {
      logic [TimeW-1:0] a;
      logic [TimeW-1:0] b;
      logic [TimeW-1:0] c;
   } alu_req_type;

   typedef struct packed {
      logic [TimeW-1:0] sum_sat;
      logic             sum_lt_c;
      logic             c_lt_sum;
   } alu_rsp_type;

endpackage
`default_nettype wire

// ----- rtl/core/rts_alu.sv -----
// Shared time unit: one saturating 63-bit add and two compares against it.
`default_nettype none
module rts_alu (
   input  wire rts_pkg::alu_req_type req,
   output rts_pkg::alu_rsp_type      rsp
);

   logic [rts_pkg::TimeW:0] sum;
   logic [rts_pkg::TimeW:0] c_ext;

   assign sum   = {1'b0, req.a} + {1'b0, req.b};
   assign c_ext = {1'b0, req.c};

   assign rsp.sum_sat  = sum[rts_pkg::TimeW] ? rts_pkg::TimeMax : sum[rts_pkg::TimeW-1:0];
   assign rsp.sum_lt_c = sum < c_ext;
   assign rsp.c_lt_sum = c_ext < sum;

endmodule
`default_nettype wire

// ----- rtl/core/repeated_timer_scheduler.sv -----
// Top level of the repeated timer scheduler: sequencer, job table and result register.
//
//   channel  ports   direction  carries
//   request  req_*   in         op, now_time, interval_ms, job_handle, target_id
//   response rsp_*   out        kind, job_id, handle_out, wake_time, last
//   csr      csr_*   in         max_wait_ms (write only)
//
// One word at a time, req_ready only when the sequencer is idle.
// Add walks the due order up to the new due time; remove and clear need no walk.
// Process: count walk over the due jobs, then per dispatched job the dispatch,
// a fix step when the due time is clamped and the reorder walk past the jobs
// it passes, then the wake word.
// All time adds and order compares run through the single rts_alu adder/comparator.
// Reset clears the table (valid bits, count) at once; no clearing pass.
// A stalled response holds the sequencer at its next emitting step.
`default_nettype none
module repeated_timer_scheduler (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [1:0]  req_op,
   input  wire [62:0] req_now_time,
   input  wire [31:0] req_interval_ms,
   input  wire [15:0] req_job_handle,
   input  wire [3:0]  req_target_id,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [3:0] rsp_job_id,
   output logic [15:0] rsp_handle_out,
   output logic [62:0] rsp_wake_time,
   output logic       rsp_last,
   input  wire        csr_write_en,
   input  wire [15:0] csr_write_data
);

   localparam int D  = rts_pkg::Depth;
   localparam int SW = rts_pkg::SlotW;
   localparam int CW = rts_pkg::CountW;
   localparam int TW = rts_pkg::TimeW;
   localparam int PW = rts_pkg::PeriodW;

   // sequencer states
   localparam logic [4:0] StIdle   = 5'd0;
   localparam logic [4:0] StEmit1  = 5'd1;
   localparam logic [4:0] StAMul   = 5'd2;
   localparam logic [4:0] StASum   = 5'd3;
   localparam logic [4:0] StAWa    = 5'd4;
   localparam logic [4:0] StAWb    = 5'd5;
   localparam logic [4:0] StAIns   = 5'd6;
   localparam logic [4:0] StRDo    = 5'd7;
   localparam logic [4:0] StPCnt   = 5'd8;
   localparam logic [4:0] StPStart = 5'd9;
   localparam logic [4:0] StPDisp  = 5'd10;
   localparam logic [4:0] StPClamp = 5'd11;
   localparam logic [4:0] StPFix   = 5'd12;
   localparam logic [4:0] StPUpd   = 5'd13;
   localparam logic [4:0] StPPos   = 5'd14;
   localparam logic [4:0] StPWalk  = 5'd15;
   localparam logic [4:0] StPRem   = 5'd16;
   localparam logic [4:0] StPIns   = 5'd17;
   localparam logic [4:0] StPNext  = 5'd18;
   localparam logic [4:0] StWMul   = 5'd19;
   localparam logic [4:0] StWSum   = 5'd20;
   localparam logic [4:0] StWCmp   = 5'd21;
   localparam logic [4:0] StWEmit  = 5'd22;

   // control state
   logic [4:0]    state_ff, state_in;
   logic [D-1:0]  valid_ff, valid_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   wait_ff, wait_in;
   logic          have_last_ff, have_last_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // job table
   logic [TW-1:0] due_ff [D], due_in [D];
   logic [PW-1:0] per_ff [D], per_in [D];
   logic [15:0]   pay_ff [D], pay_in [D];
   logic [SW-1:0] order_ff [D], order_in [D];
   logic [SW-1:0] dlist_ff [D], dlist_in [D];

   // latched request and working registers
   logic [TW-1:0] now_ff, now_in;
   logic [31:0]   ms_ff, ms_in;
   logic [15:0]   hnd_ff, hnd_in;
   logic [SW-1:0] tgt_ff, tgt_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [TW-1:0] nmax_ff, nmax_in;   // add: new due time; process: nd; end: wake
   logic          match_ff, match_in;
   logic [CW-1:0] p_ff, p_in;         // walk position
   logic [CW-1:0] ins_ff, ins_in;
   logic [CW-1:0] ndue_ff, ndue_in;
   logic [CW-1:0] j_ff, j_in;
   logic [SW-1:0] slot_ff, slot_in;   // add slot, or job being rescheduled
   logic [SW-1:0] last_now_ff, last_now_in;
   logic [SW-1:0] last_disp_ff, last_disp_in;
   logic [SW-1:0] prev_ff, prev_in;
   logic [2:0]    kind_ff, kind_in;

   // response register
   logic [2:0]    rk_ff, rk_in;
   logic [SW-1:0] rid_ff, rid_in;
   logic [15:0]   rh_ff, rh_in;
   logic [TW-1:0] rw_ff, rw_in;
   logic          rl_ff, rl_in;

   rts_pkg::alu_req_type alu_req;
   rts_pkg::alu_rsp_type alu_rsp;

   rts_alu u_alu (.req(alu_req), .rsp(alu_rsp));

   logic          out_free;
   logic          req_fire;
   logic [SW-1:0] free_slot;
   logic [SW-1:0] walk_slot;
   logic [SW-1:0] next_slot;
   logic [45:0]   mul_out;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == StIdle);
   assign req_fire  = req_valid && req_ready;
   assign walk_slot = order_ff[p_ff[SW-1:0]];
   assign next_slot = order_ff[SW'(p_ff + 5'd1)];

   // ms -> ticks, one 32x14 product
   assign mul_out = ((state_ff == StWMul) ? {16'd0, wait_ff} : ms_ff) * rts_pkg::TicksPerMs;

   always_comb begin
      free_slot = '0;
      for (int k = D - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            free_slot = SW'(k);
         end
      end
   end

   // position of a slot in the due order, count when absent
   function automatic logic [CW-1:0] pos_of(input logic [SW-1:0] s,
                                            input logic [SW-1:0] ord [D],
                                            input logic [CW-1:0] cnt);
      logic [CW-1:0] r;
      r = cnt;
      for (int k = D - 1; k >= 0; k--) begin
         if (CW'(k) < cnt && ord[k] == s) begin
            r = CW'(k);
         end
      end
      return r;
   endfunction

   always_comb begin
      logic [CW-1:0] pos;
      state_in     = state_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      wait_in      = csr_write_en ? csr_write_data : wait_ff;
      have_last_in = have_last_ff;
      due_in       = due_ff;
      per_in       = per_ff;
      pay_in       = pay_ff;
      order_in     = order_ff;
      dlist_in     = dlist_ff;
      now_in       = now_ff;
      ms_in        = ms_ff;
      hnd_in       = hnd_ff;
      tgt_in       = tgt_ff;
      prod_in      = prod_ff;
      nmax_in      = nmax_ff;
      match_in     = match_ff;
      p_in         = p_ff;
      ins_in       = ins_ff;
      ndue_in      = ndue_ff;
      j_in         = j_ff;
      slot_in      = slot_ff;
      last_now_in  = last_now_ff;
      last_disp_in = last_disp_ff;
      prev_in      = prev_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rk_in        = rk_ff;
      rid_in       = rid_ff;
      rh_in        = rh_ff;
      rw_in        = rw_ff;
      rl_in        = rl_ff;
      alu_req.a    = now_ff;
      alu_req.b    = '0;
      alu_req.c    = now_ff;
      pos          = '0;

      unique case (state_ff)
         StIdle: begin
            if (req_fire) begin
               now_in = req_now_time;
               ms_in  = req_interval_ms;
               hnd_in = req_job_handle;
               tgt_in = req_target_id;
               unique case (req_op)
                  rts_pkg::OpAdd: begin
                     if (req_interval_ms < rts_pkg::MinInterval) begin
                        kind_in  = rts_pkg::KindTooShort;
                        state_in = StEmit1;
                     end else if (count_ff >= CW'(D)) begin
                        kind_in  = rts_pkg::KindFull;
                        state_in = StEmit1;
                     end else begin
                        slot_in  = free_slot;
                        state_in = StAMul;
                     end
                  end
                  rts_pkg::OpRemove: begin
                     state_in = StRDo;
                  end
                  rts_pkg::OpProcess: begin
                     ndue_in  = '0;
                     state_in = StPCnt;
                  end
                  rts_pkg::OpClear: begin
                     valid_in = '0;
                     count_in = '0;
                     kind_in  = rts_pkg::KindCleared;
                     state_in = StEmit1;
                  end
                  default: state_in = StIdle;
               endcase
            end
         end
         StEmit1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rk_in        = kind_ff;
               rid_in       = (kind_ff == rts_pkg::KindAdded) ? slot_ff : '0;
               rh_in        = '0;
               rw_in        = '0;
               rl_in        = 1'b1;
               state_in     = StIdle;
            end
         end
         StAMul: begin
            prod_in  = mul_out;
            state_in = StASum;
         end
         StASum: begin
            alu_req.b = TW'(prod_ff);
            nmax_in   = alu_rsp.sum_sat;
            p_in      = '0;
            ins_in    = '0;
            state_in  = StAWa;
         end
         StAWa: begin
            alu_req.a = due_ff[walk_slot];
            alu_req.c = nmax_ff;
            if (p_ff == count_ff || !alu_rsp.sum_lt_c) begin
               state_in = StAIns;
            end else begin
               match_in = (per_ff[walk_slot] == prod_ff);
               state_in = StAWb;
            end
         end
         StAWb: begin
            // batch when due + one second exceeds the candidate time
            alu_req.a = due_ff[walk_slot];
            alu_req.b = rts_pkg::TicksPerSec;
            alu_req.c = nmax_ff;
            if (match_ff && alu_rsp.c_lt_sum) begin
               nmax_in = due_ff[walk_slot];
            end
            ins_in   = p_ff + 5'd1;
            p_in     = p_ff + 5'd1;
            state_in = StAWa;
         end
         StAIns: begin
            valid_in[slot_ff] = 1'b1;
            due_in[slot_ff]   = nmax_ff;
            per_in[slot_ff]   = prod_ff;
            pay_in[slot_ff]   = hnd_ff;
            for (int k = 1; k < D; k++) begin
               if (CW'(k) > ins_ff) begin
                  order_in[k] = order_ff[k-1];
               end
            end
            order_in[ins_ff[SW-1:0]] = slot_ff;
            count_in = count_ff + 5'd1;
            kind_in  = rts_pkg::KindAdded;
            state_in = StEmit1;
         end
         StRDo: begin
            if (valid_ff[tgt_ff]) begin
               pos = pos_of(tgt_ff, order_ff, count_ff);
               for (int k = 0; k < D - 1; k++) begin
                  if (CW'(k) >= pos) begin
                     order_in[k] = order_ff[k+1];
                  end
               end
               if (pos < count_ff) begin
                  count_in = count_ff - 5'd1;
               end
               valid_in[tgt_ff] = 1'b0;
            end
            kind_in  = rts_pkg::KindRemoved;
            state_in = StEmit1;
         end
         StPCnt: begin
            alu_req.a = due_ff[order_ff[ndue_ff[SW-1:0]]];
            alu_req.c = now_ff;
            if (ndue_ff == count_ff || alu_rsp.c_lt_sum) begin
               state_in = StPStart;
            end else begin
               dlist_in[ndue_ff[SW-1:0]] = order_ff[ndue_ff[SW-1:0]];
               ndue_in = ndue_ff + 5'd1;
            end
         end
         StPStart: begin
            if (ndue_ff == '0) begin
               state_in = StWMul;
            end else begin
               last_now_in  = dlist_ff[SW'(ndue_ff - 5'd1)];
               j_in         = '0;
               have_last_in = 1'b0;
               state_in     = StPDisp;
            end
         end
         StPDisp: begin
            alu_req.a = due_ff[dlist_ff[j_ff[SW-1:0]]];
            alu_req.b = TW'(per_ff[dlist_ff[j_ff[SW-1:0]]]);
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rk_in        = rts_pkg::KindDispatch;
               rid_in       = dlist_ff[j_ff[SW-1:0]];
               rh_in        = pay_ff[dlist_ff[j_ff[SW-1:0]]];
               rw_in        = '0;
               rl_in        = 1'b0;
               slot_in      = dlist_ff[j_ff[SW-1:0]];
               nmax_in      = alu_rsp.sum_sat;
               state_in     = StPClamp;
            end
         end
         StPClamp: begin
            alu_req.a = nmax_ff;
            alu_req.c = now_ff;
            state_in  = alu_rsp.sum_lt_c ? StPFix : StPUpd;
         end
         StPFix: begin
            alu_req.b = TW'(1);
            nmax_in   = alu_rsp.sum_sat;
            state_in  = StPUpd;
         end
         StPUpd: begin
            due_in[slot_ff] = nmax_ff;
            state_in        = StPPos;
         end
         StPPos: begin
            if (have_last_ff && due_ff[last_disp_ff] == nmax_ff) begin
               prev_in  = last_disp_ff;
               state_in = StPRem;
            end else begin
               p_in     = pos_of(last_now_ff, order_ff, count_ff);
               state_in = StPWalk;
            end
         end
         StPWalk: begin
            alu_req.a = due_ff[next_slot];
            alu_req.c = nmax_ff;
            if (p_ff + 5'd1 >= count_ff || !alu_rsp.sum_lt_c) begin
               prev_in  = walk_slot;
               state_in = StPRem;
            end else begin
               p_in = p_ff + 5'd1;
            end
         end
         StPRem: begin
            if (prev_ff == slot_ff) begin
               state_in = StPNext;
            end else begin
               pos = pos_of(slot_ff, order_ff, count_ff);
               for (int k = 0; k < D - 1; k++) begin
                  if (CW'(k) >= pos) begin
                     order_in[k] = order_ff[k+1];
                  end
               end
               count_in = count_ff - 5'd1;
               state_in = StPIns;
            end
         end
         StPIns: begin
            pos = pos_of(prev_ff, order_ff, count_ff) + 5'd1;
            for (int k = 1; k < D; k++) begin
               if (CW'(k) > pos) begin
                  order_in[k] = order_ff[k-1];
               end
            end
            order_in[pos[SW-1:0]] = slot_ff;
            count_in = count_ff + 5'd1;
            state_in = StPNext;
         end
         StPNext: begin
            last_disp_in = slot_ff;
            have_last_in = 1'b1;
            j_in         = j_ff + 5'd1;
            state_in     = (j_ff + 5'd1 == ndue_ff) ? StWMul : StPDisp;
         end
         StWMul: begin
            prod_in  = mul_out;
            state_in = StWSum;
         end
         StWSum: begin
            alu_req.b = TW'(prod_ff);
            nmax_in   = alu_rsp.sum_sat;
            state_in  = StWCmp;
         end
         StWCmp: begin
            alu_req.a = due_ff[order_ff[0]];
            alu_req.c = nmax_ff;
            if (count_ff != '0 && alu_rsp.sum_lt_c) begin
               nmax_in = due_ff[order_ff[0]];
            end
            state_in = StWEmit;
         end
         StWEmit: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rk_in        = rts_pkg::KindWake;
               rid_in       = '0;
               rh_in        = '0;
               rw_in        = nmax_ff;
               rl_in        = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         valid_ff     <= '0;
         count_ff     <= '0;
         wait_ff      <= rts_pkg::WaitReset;
         have_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         have_last_ff <= have_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      due_ff       <= due_in;
      per_ff       <= per_in;
      pay_ff       <= pay_in;
      order_ff     <= order_in;
      dlist_ff     <= dlist_in;
      now_ff       <= now_in;
      ms_ff        <= ms_in;
      hnd_ff       <= hnd_in;
      tgt_ff       <= tgt_in;
      prod_ff      <= prod_in;
      nmax_ff      <= nmax_in;
      match_ff     <= match_in;
      p_ff         <= p_in;
      ins_ff       <= ins_in;
      ndue_ff      <= ndue_in;
      j_ff         <= j_in;
      slot_ff      <= slot_in;
      last_now_ff  <= last_now_in;
      last_disp_ff <= last_disp_in;
      prev_ff      <= prev_in;
      kind_ff      <= kind_in;
      rk_ff        <= rk_in;
      rid_ff       <= rid_in;
      rh_ff        <= rh_in;
      rw_ff        <= rw_in;
      rl_ff        <= rl_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rk_ff;
   assign rsp_job_id     = rid_ff;
   assign rsp_handle_out = rh_ff;
   assign rsp_wake_time  = rw_ff;
   assign rsp_last       = rl_ff;

   // table never holds more jobs than slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(D))
      else $error("job count above table depth");

   // between words, the job count equals the number of valid slots
   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == StIdle |-> $countones(valid_ff) == 32'(count_ff))
      else $error("job count out of step with valid slots");

   // a dispatch is never the closing word, a wake word always is
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rl_ff == (rk_ff != rts_pkg::KindDispatch)))
      else $error("last flag does not match word kind");

   // process always ends through the wake word
   a_wake_follows: assert property (@(posedge clock) disable iff (reset)
      state_ff == StWEmit && out_free |=> rsp_valid_ff && rk_ff == rts_pkg::KindWake)
      else $error("wake word not issued");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the repeated timer scheduler: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = rts_pkg::OpClear;
   logic [62:0] req_now_time = '0;
   logic [31:0] req_interval_ms = '0;
   logic [15:0] req_job_handle = '0;
   logic [3:0]  req_target_id = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [3:0]  rsp_job_id;
   logic [15:0] rsp_handle_out;
   logic [62:0] rsp_wake_time;
   logic        rsp_last;
   logic        csr_write_en = 1'b0;
   logic [15:0] csr_write_data = '0;

   repeated_timer_scheduler u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_now_time(req_now_time), .req_interval_ms(req_interval_ms),
      .req_job_handle(req_job_handle), .req_target_id(req_target_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_job_id(rsp_job_id), .rsp_handle_out(rsp_handle_out),
      .rsp_wake_time(rsp_wake_time), .rsp_last(rsp_last),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // one result word
   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  job_id;
      logic [15:0] handle;
      logic [62:0] wake;
      logic        last;
   } sched_word_type;

   // one request word; hard-coded expectation used only when has_exp is set
   typedef struct {
      logic [1:0]  op;
      logic [62:0] now;
      logic [31:0] ms;
      logic [15:0] handle;
      logic [3:0]  target;
      bit          has_exp;
      logic [2:0]  exp_kind;
      logic [3:0]  exp_id;
   } sched_req_type;

   sched_word_type pending_words[$];
   int          error_count = 0;
   longint      cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   localparam longint CycleLimit = 2_000_000;

   // shadow scheduler state
   logic [15:0] sh_max_wait;
   bit          sh_valid[rts_pkg::Depth];
   logic [62:0] sh_due[rts_pkg::Depth];
   logic [62:0] sh_period[rts_pkg::Depth];
   logic [15:0] sh_payload[rts_pkg::Depth];
   int          sh_order[rts_pkg::Depth];
   int          sh_count;

   function automatic logic [62:0] time_sum(logic [62:0] a, logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? rts_pkg::TimeMax : s[62:0];
   endfunction

   function automatic int order_pos(int slot);
      for (int p = 0; p < sh_count; p++)
         if (sh_order[p] == slot) return p;
      return sh_count;
   endfunction

   function automatic void order_drop(int p);
      if (p >= sh_count) return;
      for (int i = p; i + 1 < sh_count; i++) sh_order[i] = sh_order[i+1];
      sh_count--;
   endfunction

   function automatic void order_put(int p, int slot);
      if (sh_count >= rts_pkg::Depth || p > sh_count) return;
      for (int i = sh_count; i > p; i--) sh_order[i] = sh_order[i-1];
      sh_order[p] = slot;
      sh_count++;
   endfunction

   function automatic void push_word(logic [2:0] k, logic [3:0] id, logic [15:0] h,
                                     logic [62:0] w, logic l);
      sched_word_type x;
      x.kind = k; x.job_id = id; x.handle = h; x.wake = w; x.last = l;
      pending_words.push_back(x);
   endfunction

   // advance shadow state by one request, queue the words it yields
   function automatic void schedule_step(sched_req_type r);
      int slot, ins, ndue, last_now, last_disp, prev, p;
      int due_slots[rts_pkg::Depth];
      bit have_last;
      logic [62:0] per, nmax, nd, d, wake;
      case (r.op)
         rts_pkg::OpAdd: begin
            if (r.ms < rts_pkg::MinInterval) begin
               push_word(rts_pkg::KindTooShort, 0, 0, 0, 1);
               return;
            end
            slot = 0;
            while (slot < rts_pkg::Depth && sh_valid[slot]) slot++;
            if (sh_count >= rts_pkg::Depth || slot >= rts_pkg::Depth) begin
               push_word(rts_pkg::KindFull, 0, 0, 0, 1);
               return;
            end
            per = 63'(r.ms) * 63'(rts_pkg::TicksPerMs);
            nmax = time_sum(r.now, per);
            ins = 0;
            for (p = 0; p < sh_count; p++) begin
               d = sh_due[sh_order[p]];
               if (d >= nmax) break;
               // batch with a same-period job due within a second before
               if (sh_period[sh_order[p]] == per &&
                   (nmax < rts_pkg::TicksPerSec || d > nmax - rts_pkg::TicksPerSec))
                  nmax = d;
               ins = p + 1;
            end
            sh_valid[slot] = 1;
            sh_due[slot] = nmax;
            sh_period[slot] = per;
            sh_payload[slot] = r.handle;
            order_put(ins, slot);
            push_word(rts_pkg::KindAdded, 4'(slot), 0, 0, 1);
         end
         rts_pkg::OpRemove: begin
            if (sh_valid[r.target]) begin
               order_drop(order_pos(r.target));
               sh_valid[r.target] = 0;
            end
            push_word(rts_pkg::KindRemoved, 0, 0, 0, 1);
         end
         rts_pkg::OpProcess: begin
            ndue = 0; last_now = 0; last_disp = 0; have_last = 0;
            while (ndue < sh_count && sh_due[sh_order[ndue]] <= r.now) begin
               due_slots[ndue] = sh_order[ndue];
               ndue++;
            end
            if (ndue > 0) last_now = due_slots[ndue-1];
            for (int j = 0; j < ndue; j++) begin
               slot = due_slots[j];
               push_word(rts_pkg::KindDispatch, 4'(slot), sh_payload[slot], 0, 0);
               nd = time_sum(sh_due[slot], sh_period[slot]);
               if (nd < r.now) nd = time_sum(r.now, 63'd1);  // stale: push to now+1
               sh_due[slot] = nd;
               if (have_last && sh_due[last_disp] == nd) prev = last_disp;
               else begin
                  prev = last_now;
                  forever begin
                     p = order_pos(prev);
                     if (p + 1 >= sh_count || sh_due[sh_order[p+1]] >= nd) break;
                     prev = sh_order[p+1];
                  end
               end
               if (prev != slot) begin
                  order_drop(order_pos(slot));
                  order_put(order_pos(prev) + 1, slot);
               end
               last_disp = slot;
               have_last = 1;
            end
            wake = time_sum(r.now, 63'(sh_max_wait) * 63'(rts_pkg::TicksPerMs));
            if (sh_count > 0 && sh_due[sh_order[0]] < wake) wake = sh_due[sh_order[0]];
            push_word(rts_pkg::KindWake, 0, 0, wake, 1);
         end
         default: begin
            for (int i = 0; i < rts_pkg::Depth; i++) sh_valid[i] = 0;
            sh_count = 0;
            push_word(rts_pkg::KindCleared, 0, 0, 0, 1);
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch @%0d: %s got %0h want %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   // cycle counter and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stall, compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      sched_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0)
            report_mismatch("unexpected word", 64'(rsp_kind), 64'd0);
         else begin
            want = pending_words.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch("kind", 64'(rsp_kind), 64'(want.kind));
            if (rsp_job_id !== want.job_id)
               report_mismatch("job_id", 64'(rsp_job_id), 64'(want.job_id));
            if (rsp_handle_out !== want.handle)
               report_mismatch("handle_out", 64'(rsp_handle_out), 64'(want.handle));
            if (rsp_wake_time !== want.wake)
               report_mismatch("wake_time", 64'(rsp_wake_time), 64'(want.wake));
            if (rsp_last !== want.last)
               report_mismatch("last", 64'(rsp_last), 64'(want.last));
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // drive one request word and hold it until accepted
   task automatic send_req(sched_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_op <= r.op;
      req_now_time <= r.now;
      req_interval_ms <= r.ms;
      req_job_handle <= r.handle;
      req_target_id <= r.target;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // word taken at this edge; predict now
      schedule_step(r);
      if (r.has_exp && pending_words.size() > 0 &&
          pending_words[pending_words.size()-1].kind !== r.exp_kind) begin
         report_mismatch("table kind", 64'(pending_words[pending_words.size()-1].kind),
                         64'(r.exp_kind));
      end
      if (r.has_exp && r.exp_kind == rts_pkg::KindAdded &&
          pending_words[pending_words.size()-1].job_id !== r.exp_id)
         report_mismatch("table job_id", 64'(pending_words[pending_words.size()-1].job_id),
                         64'(r.exp_id));
   endtask

   // wait for all words, then a quiet tail, before touching the register
   task automatic drain();
      req_valid <= 0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_wait(logic [15:0] v);
      drain();
      csr_write_en <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 0;
      sh_max_wait = v;
   endtask

   function automatic sched_req_type mk(logic [1:0] op, logic [62:0] now, logic [31:0] ms,
                                        logic [15:0] h, logic [3:0] t, bit he,
                                        logic [2:0] ek, logic [3:0] ei);
      sched_req_type r;
      r.op = op; r.now = now; r.ms = ms; r.handle = h; r.target = t;
      r.has_exp = he; r.exp_kind = ek; r.exp_id = ei;
      return r;
   endfunction

   function automatic logic [62:0] rand_time();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      return v[62:0];
   endfunction

   sched_req_type directed[$];
   logic [62:0] clock_now;

   initial begin
      sched_req_type r;
      sh_max_wait = rts_pkg::WaitReset;
      sh_count = 0;
      for (int i = 0; i < rts_pkg::Depth; i++) sh_valid[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed table: extremes, every op, batching, stale, saturation, full
      directed.push_back(mk(rts_pkg::OpProcess, 0, 0, 0, 0, 0, 0, 0));  // empty table wake
      directed.push_back(mk(rts_pkg::OpAdd, 0, 0, 16'hFFFF, 0, 1, rts_pkg::KindTooShort, 0));
      directed.push_back(mk(rts_pkg::OpAdd, 0, 4, 0, 0, 1, rts_pkg::KindTooShort, 0));
      directed.push_back(mk(rts_pkg::OpAdd, 0, 5, 16'h1234, 0, 1, rts_pkg::KindAdded, 0));
      directed.push_back(mk(rts_pkg::OpAdd, 1000, 5, 16'hFFFF, 0, 1,
                            rts_pkg::KindAdded, 1));   // batched
      directed.push_back(mk(rts_pkg::OpAdd, 0, 32'hFFFFFFFF, 16'h00AA, 0, 1,
                            rts_pkg::KindAdded, 2));
      directed.push_back(mk(rts_pkg::OpAdd, rts_pkg::TimeMax - 5, 100, 16'h5555, 0, 1,
                            rts_pkg::KindAdded, 3)); // sat
      directed.push_back(mk(rts_pkg::OpProcess, 50000, 0, 0, 0, 0, 0, 0));   // due exactly
      directed.push_back(mk(rts_pkg::OpProcess, 5000000, 0, 0, 0, 0, 0, 0)); // stale reschedule
      directed.push_back(mk(rts_pkg::OpRemove, 0, 0, 0, 4'd15, 1,
                            rts_pkg::KindRemoved, 0)); // free slot
      directed.push_back(mk(rts_pkg::OpRemove, 0, 0, 0, 4'd1, 1, rts_pkg::KindRemoved, 0));
      directed.push_back(mk(rts_pkg::OpProcess, rts_pkg::TimeMax, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(rts_pkg::OpClear, 0, 0, 0, 0, 1, rts_pkg::KindCleared, 0));
      for (int i = 0; i < rts_pkg::Depth; i++)
         directed.push_back(mk(rts_pkg::OpAdd, 63'(i) * 7, 10, 16'(i), 0, 1,
                               rts_pkg::KindAdded, 4'(i)));
      directed.push_back(mk(rts_pkg::OpAdd, 0, 2, 0, 0, 1,
                            rts_pkg::KindTooShort, 0)); // interval check first
      directed.push_back(mk(rts_pkg::OpAdd, 0, 20, 0, 0, 1, rts_pkg::KindFull, 0));
      directed.push_back(mk(rts_pkg::OpProcess, 200000, 0, 0, 0, 0, 0, 0)); // sixteen dispatches
      foreach (directed[i]) send_req(directed[i]);

      write_wait(16'd0);
      send_req(mk(rts_pkg::OpProcess, 1, 0, 0, 0, 0, 0, 0));
      write_wait(16'hFFFF);
      send_req(mk(rts_pkg::OpProcess, rts_pkg::TimeMax - 3, 0, 0, 0, 0, 0, 0));
      send_req(mk(rts_pkg::OpClear, 0, 0, 0, 0, 0, 0, 0));
      write_wait(16'd1);

      // random phases: mostly add/process on a forward clock, some noise
      clock_now = 0;
      for (int n = 0; n < 120; n++) begin
         int sel;
         case (n / 32)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            3: begin send_idle_pct = 16; recv_stall_pct = 16; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (n == 80) begin
            drain();     // sender holds until everything is back
            write_wait(16'($urandom_range(1, 65535)));
         end
         sel = $urandom_range(99);
         clock_now = time_sum(clock_now, 63'($urandom_range(0, 300000)));
         if (sel < 40)
            r = mk(rts_pkg::OpAdd, clock_now, $urandom_range(0, 3) == 0 ? $urandom() :
                   32'($urandom_range(0, 120)), 16'($urandom()), 0, 0, 0, 0);
         else if (sel < 75) r = mk(rts_pkg::OpProcess, clock_now, 0, 0, 0, 0, 0, 0);
         else if (sel < 90) r = mk(rts_pkg::OpRemove, 0, 0, 0, 4'($urandom()), 0, 0, 0);
         else if (sel < 95) r = mk(rts_pkg::OpClear, 0, 0, 0, 0, 0, 0, 0);
         else r = mk($urandom_range(0, 1) ? rts_pkg::OpAdd : rts_pkg::OpProcess, rand_time(),
                     $urandom(), 16'($urandom()), 0, 0, 0, 0);
         if (sel >= 95) clock_now = r.now;
         send_req(r);
      end

      drain();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ----- repeated_timer_scheduler.f -----
rtl/core/rts_pkg.sv
rtl/core/rts_alu.sv
rtl/core/repeated_timer_scheduler.sv
tb/sv/tb_top.sv
